/* src/chacha_pkg.sv */
package chacha_pkg;

   // ChaCha constant words ("expand 32-byte k")
   localparam logic [31:0] SIGMA0 = 32'h6170_7865;
   localparam logic [31:0] SIGMA1 = 32'h3320_646e;
   localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
   localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

   localparam int DOUBLE_ROUNDS_DEF = 10;

   // CSR geometry: 64-bit registers at byte address 8*index
   localparam int CSR_AW = 6;
   localparam int CSR_DW = 64;
   localparam int REG_IDX_W = 3;

   localparam logic [REG_IDX_W-1:0] REG_KEY_0_7    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_KEY_8_15   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_KEY_16_23  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_KEY_24_31  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_NONCE_0_7  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_NONCE_8_11 = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_START_CTR  = 3'd6;

   // configuration as seen by the datapath
   typedef struct packed {
      logic [255:0] key;
      logic [95:0]  nonce;
      logic [31:0]  start_ctr;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic       latch;       // capture the accepted transaction
      logic       start_msg;   // load block counter from config, rewind position
      logic       init_blk;    // load working state from config and counter
      logic       round_step;  // one quarter-round line on all four lanes
      logic [1:0] step;        // which line of the quarter round
      logic       diag;        // diagonal round when set, column round when clear
      logic       finish_blk;  // feed-forward add into keystream, bump counter
      logic       emit;        // produce a result into the output register
      logic       emit_live;   // emit from the live request instead of the latch
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic slot_free;  // output register free or being taken this cycle
      logic pos_last;   // current keystream byte is the last of the block
      logic last_q;     // latched last flag
   } stat_type;

endpackage

/* src/chacha_ctrl.sv */
module chacha_ctrl import chacha_pkg::*; #(
   parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_last_byte,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam int HALF_ROUNDS = 2 * DOUBLE_ROUNDS;
   localparam int HW = $clog2(HALF_ROUNDS);
   localparam logic [HW-1:0] HALF_LAST = HW'(HALF_ROUNDS - 1);
   localparam logic [1:0] STEP_LAST = 2'd3;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_ROUND = 2'd1;
   localparam logic [1:0] S_FINAL = 2'd2;
   localparam logic [1:0] S_EMIT  = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [1:0]    step_ff, step_in;
   logic [HW-1:0] half_ff, half_in;
   logic          open_ff, open_in;
   logic          ready_ff, ready_in;

   // next-state and command decode
   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      half_in        = half_ff;
      open_in        = open_ff;
      ready_in       = ready_ff;
      req_stall      = 1'b1;
      cmd            = '0;
      cmd.step       = step_ff;
      cmd.diag       = half_ff[0];
      case (state_ff)
         S_IDLE: begin
            req_stall = !stat.slot_free;
            if (req_valid && stat.slot_free) begin
               cmd.latch = 1'b1;
               if (!open_ff || !ready_ff) begin
                  // new message or block boundary: compute a block first
                  cmd.start_msg = !open_ff;
                  cmd.init_blk  = 1'b1;
                  open_in       = 1'b1;
                  ready_in      = 1'b0;
                  step_in       = '0;
                  half_in       = '0;
                  state_in      = S_ROUND;
               end else begin
                  cmd.emit      = 1'b1;
                  cmd.emit_live = 1'b1;
                  ready_in      = !stat.pos_last;
                  open_in       = !req_last_byte;
               end
            end
         end
         S_ROUND: begin
            cmd.round_step = 1'b1;
            step_in        = 2'(step_ff + 2'd1);
            if (step_ff == STEP_LAST) begin
               half_in = HW'(half_ff + 1'b1);
               if (half_ff == HALF_LAST) begin
                  half_in  = '0;
                  state_in = S_FINAL;
               end
            end
         end
         S_FINAL: begin
            cmd.finish_blk = 1'b1;
            ready_in       = 1'b1;
            state_in       = S_EMIT;
         end
         S_EMIT: begin
            if (stat.slot_free) begin
               cmd.emit = 1'b1;
               ready_in = !stat.pos_last;
               open_in  = !stat.last_q;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
         half_ff  <= '0;
         open_ff  <= 1'b0;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         half_ff  <= half_in;
         open_ff  <= open_in;
         ready_ff <= ready_in;
      end
   end

endmodule

/* src/chacha_dp.sv */
module chacha_dp import chacha_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  cmd_type    cmd,
   output stat_type   stat,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output logic [7:0] rsp_result_byte,
   output logic       rsp_result_last
);

   logic [31:0] work_ff [16];
   logic [31:0] work_in [16];
   logic [31:0] ks_ff [16];
   logic [31:0] init_w [16];
   logic [31:0] ctr;
   logic [5:0]  pos_ff, pos_in;
   logic [31:0] blk_ff, blk_in;
   logic [7:0]  data_q_ff;
   logic        last_q_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff;
   logic        rsp_last_ff;
   logic [31:0] ks_word;
   logic [7:0]  ks_byte;
   logic [7:0]  emit_data;
   logic        emit_last;

   // rotate left by the amount of the given quarter-round line
   function automatic logic [31:0] rot_step(input logic [31:0] v, input logic [1:0] s);
      logic [31:0] r;
      case (s)
         2'd0:    r = {v[15:0], v[31:16]};
         2'd1:    r = {v[19:0], v[31:20]};
         2'd2:    r = {v[23:0], v[31:24]};
         default: r = {v[24:0], v[31:25]};
      endcase
      return r;
   endfunction

   // block input words
   assign ctr = cmd.start_msg ? cfg.start_ctr : blk_ff;
   always_comb begin
      init_w[0] = SIGMA0;
      init_w[1] = SIGMA1;
      init_w[2] = SIGMA2;
      init_w[3] = SIGMA3;
      for (int i = 0; i < 8; i++) begin
         init_w[4+i] = cfg.key[32*i +: 32];
      end
      init_w[12] = ctr;
      init_w[13] = cfg.nonce[31:0];
      init_w[14] = cfg.nonce[63:32];
      init_w[15] = cfg.nonce[95:64];
   end

   // one quarter-round line on four independent lanes:
   // p += q; t = rotl(t ^ p, r); even lines use (a,b,d), odd lines (c,d,b)
   always_comb begin
      logic [3:0]  ia, ib, ic, id, ip, iq, it;
      logic [31:0] sum;
      for (int k = 0; k < 16; k++) begin
         work_in[k] = work_ff[k];
      end
      for (int j = 0; j < 4; j++) begin
         ia = 4'(j);
         ib = cmd.diag ? 4'(4 + ((j + 1) % 4)) : 4'(4 + j);
         ic = cmd.diag ? 4'(8 + ((j + 2) % 4)) : 4'(8 + j);
         id = cmd.diag ? 4'(12 + ((j + 3) % 4)) : 4'(12 + j);
         ip = cmd.step[0] ? ic : ia;
         iq = cmd.step[0] ? id : ib;
         it = cmd.step[0] ? ib : id;
         sum = work_ff[ip] + work_ff[iq];
         work_in[ip] = sum;
         work_in[it] = rot_step(work_ff[it] ^ sum, cmd.step);
      end
   end

   // working state
   always_ff @(posedge clock) begin
      if (cmd.init_blk) begin
         work_ff <= init_w;
      end else if (cmd.round_step) begin
         work_ff <= work_in;
      end
   end

   // keystream block with feed-forward add
   always_ff @(posedge clock) begin
      if (cmd.finish_blk) begin
         for (int k = 0; k < 16; k++) begin
            ks_ff[k] <= work_ff[k] + init_w[k];
         end
      end
   end

   // latched transaction
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         data_q_ff <= req_data_byte;
         last_q_ff <= req_last_byte;
      end
   end

   // keystream byte at the current position
   assign ks_word   = ks_ff[pos_ff[5:2]];
   assign ks_byte   = ks_word[{pos_ff[1:0], 3'b000} +: 8];
   assign emit_data = cmd.emit_live ? req_data_byte : data_q_ff;
   assign emit_last = cmd.emit_live ? req_last_byte : last_q_ff;

   // position and block counter
   always_comb begin
      pos_in = pos_ff;
      blk_in = blk_ff;
      if (cmd.start_msg) begin
         pos_in = '0;
         blk_in = cfg.start_ctr;
      end
      if (cmd.finish_blk) begin
         blk_in = blk_ff + 32'd1;
      end
      if (cmd.emit) begin
         pos_in = 6'(pos_ff + 6'd1);
      end
   end

   assign rsp_valid_in = cmd.emit | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         blk_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         blk_ff       <= blk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_byte_ff <= emit_data ^ ks_byte;
         rsp_last_ff <= emit_last;
      end
   end

   assign stat.slot_free = !rsp_valid_ff || !rsp_stall;
   assign stat.pos_last  = (pos_ff == 6'd63);
   assign stat.last_q    = last_q_ff;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_byte = rsp_byte_ff;
   assign rsp_result_last = rsp_last_ff;

endmodule

/* src/chacha20_stream_xor.sv */
// A byte inside an already computed block shows on rsp in the cycle after it is taken.
// The first byte of a block waits for the block: the working state is loaded, the round unit
// does one quarter-round line on four lanes per cycle, then the feed-forward add is made.
// Throughput: one byte per cycle within a block while the output is not stalled.
// Reset is synchronous and active high; it clears the controller, counters, output valid
// and all configuration registers to zero.
module chacha20_stream_xor import chacha_pkg::*; #(
   parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_data_byte,
   input  logic              req_last_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_result_byte,
   output logic              rsp_result_last,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   logic [63:0]          key0_ff, key1_ff, key2_ff, key3_ff, nonce_lo_ff;
   logic [31:0]          nonce_hi_ff, start_ff;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_en;
   cfg_type              cfg;
   cmd_type              cmd;
   stat_type             stat;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_AW-1:3];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff     <= '0;
         key1_ff     <= '0;
         key2_ff     <= '0;
         key3_ff     <= '0;
         nonce_lo_ff <= '0;
         nonce_hi_ff <= '0;
         start_ff    <= '0;
      end else if (wr_en) begin
         case (reg_idx)
            REG_KEY_0_7:    key0_ff     <= csr_pwdata;
            REG_KEY_8_15:   key1_ff     <= csr_pwdata;
            REG_KEY_16_23:  key2_ff     <= csr_pwdata;
            REG_KEY_24_31:  key3_ff     <= csr_pwdata;
            REG_NONCE_0_7:  nonce_lo_ff <= csr_pwdata;
            REG_NONCE_8_11: nonce_hi_ff <= csr_pwdata[31:0];
            REG_START_CTR:  start_ff    <= csr_pwdata[31:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      case (reg_idx)
         REG_KEY_0_7:    csr_prdata = key0_ff;
         REG_KEY_8_15:   csr_prdata = key1_ff;
         REG_KEY_16_23:  csr_prdata = key2_ff;
         REG_KEY_24_31:  csr_prdata = key3_ff;
         REG_NONCE_0_7:  csr_prdata = nonce_lo_ff;
         REG_NONCE_8_11: csr_prdata = {32'd0, nonce_hi_ff};
         REG_START_CTR:  csr_prdata = {32'd0, start_ff};
         default:        csr_prdata = '0;
      endcase
   end

   assign cfg.key       = {key3_ff, key2_ff, key1_ff, key0_ff};
   assign cfg.nonce     = {nonce_hi_ff, nonce_lo_ff};
   assign cfg.start_ctr = start_ff;

   chacha_ctrl #(
      .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_byte (req_last_byte),
      .req_stall     (req_stall),
      .stat          (stat),
      .cmd           (cmd)
   );

   chacha_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .stat            (stat),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_result_byte (rsp_result_byte),
      .rsp_result_last (rsp_result_last)
   );

endmodule

/* src/chacha_chk.sv */
module chacha_chk (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_result_byte,
   input logic       rsp_result_last
);

   logic       req_fire, rsp_fire;
   logic [1:0] pend_ff, pend_in;

   assign req_fire = req_valid & !req_stall;
   assign rsp_fire = rsp_valid & !rsp_stall;

   // transactions taken but not yet delivered
   always_comb begin
      pend_in = pend_ff;
      if (req_fire && !rsp_fire) begin
         pend_in = 2'(pend_ff + 2'd1);
      end else if (!req_fire && rsp_fire) begin
         pend_in = 2'(pend_ff - 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // a held result stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // a held result does not change
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_result_byte) && $stable(rsp_result_last))
      else $error("result changed while stalled");

   // no result without an outstanding transaction
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result without a matching transaction");

   // input is taken only when the output register is free or draining,
   // so at most one transaction is in work or waiting in the output register
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff < 2'd2)
      else $error("too many transactions in flight");

endmodule

bind chacha20_stream_xor chacha_chk u_chk (.*);

/* bench/tb_chacha20_stream_xor.sv */
`timescale 1ns / 1ps

module tb_chacha20_stream_xor import chacha_pkg::*; ();

   localparam int SETTLE_CYCLES = 100;   // covers the block computation
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_COUNT = 10;
   localparam int PHASE_BYTES = 150;
   localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

   typedef logic [15:0][31:0] words_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } plain_in_type;

   typedef struct packed {
      logic [7:0] result_byte;
      logic       result_last;
   } cipher_out_type;

   typedef enum int {CFG_ONES, CFG_ZEROS, CFG_RANDOM} cfg_mode_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [7:0]        req_data_byte = 8'h00;
   logic              req_last_byte = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [7:0]        rsp_result_byte;
   logic              rsp_result_last;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   // bytes waiting to be sent and ciphertext bytes waiting to come back
   plain_in_type   plain_q[$];
   cipher_out_type cipher_q[$];

   int send_idle_pct = 34;
   int recv_idle_pct = 70;
   int error_count = 0;
   int quiet_cycles = 0;

   // predictor copy of the configuration
   logic [63:0] key_reg [4];
   logic [63:0] nonce_lo = '0;
   logic [31:0] nonce_hi = '0;
   logic [31:0] start_ctr_reg = '0;

   // predictor keystream state
   words_type   ks_words = '0;
   logic [5:0]  ks_pos = '0;
   logic [31:0] blk_ctr = '0;
   logic        blk_valid = 1'b0;
   logic        msg_open = 1'b0;

   always #6 clock = ~clock;

   chacha20_stream_xor DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_byte (rsp_result_byte),
      .rsp_result_last (rsp_result_last),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   function automatic logic [31:0] rotl32(logic [31:0] v, int s);
      return (v << s) | (v >> (32 - s));
   endfunction

   function automatic words_type quarter_round(words_type w, int a, int b, int c, int d);
      w[a] = w[a] + w[b]; w[d] = rotl32(w[d] ^ w[a], 16);
      w[c] = w[c] + w[d]; w[b] = rotl32(w[b] ^ w[c], 12);
      w[a] = w[a] + w[b]; w[d] = rotl32(w[d] ^ w[a], 8);
      w[c] = w[c] + w[d]; w[b] = rotl32(w[b] ^ w[c], 7);
      return w;
   endfunction

   // one 64-byte keystream block from the current key, nonce and a counter
   function automatic words_type chacha_block(logic [31:0] ctr);
      words_type init;
      words_type w;
      init[0] = SIGMA0;
      init[1] = SIGMA1;
      init[2] = SIGMA2;
      init[3] = SIGMA3;
      for (int k = 0; k < 4; k++) begin
         init[4 + 2*k] = key_reg[k][31:0];
         init[5 + 2*k] = key_reg[k][63:32];
      end
      init[12] = ctr;
      init[13] = nonce_lo[31:0];
      init[14] = nonce_lo[63:32];
      init[15] = nonce_hi;
      w = init;
      for (int r = 0; r < DOUBLE_ROUNDS_DEF; r++) begin
         w = quarter_round(w, 0, 4, 8, 12);
         w = quarter_round(w, 1, 5, 9, 13);
         w = quarter_round(w, 2, 6, 10, 14);
         w = quarter_round(w, 3, 7, 11, 15);
         w = quarter_round(w, 0, 5, 10, 15);
         w = quarter_round(w, 1, 6, 11, 12);
         w = quarter_round(w, 2, 7, 8, 13);
         w = quarter_round(w, 3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++)
         w[i] = w[i] + init[i];
      return w;
   endfunction

   // advance the keystream by one byte and queue the expected ciphertext
   task automatic xor_keystream(input logic [7:0] data, input logic last);
      logic [31:0] word;
      cipher_out_type want;
      if (!msg_open) begin
         blk_ctr = start_ctr_reg;
         ks_pos = '0;
         blk_valid = 1'b0;
         msg_open = 1'b1;
      end
      if (!blk_valid) begin
         ks_words = chacha_block(blk_ctr);
         blk_ctr = blk_ctr + 32'd1;
         blk_valid = 1'b1;
      end
      word = ks_words[ks_pos[5:2]];
      want.result_byte = data ^ word[ks_pos[1:0]*8 +: 8];
      want.result_last = last;
      cipher_q.push_back(want);
      ks_pos = ks_pos + 6'd1;
      if (ks_pos == 6'd0)
         blk_valid = 1'b0;
      if (last)
         msg_open = 1'b0;
   endtask

   // register write: setup cycle, then access cycle until pready
   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input logic [CSR_DW-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_AW'(idx) << 3;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_KEY_0_7:    key_reg[0] = value;
         REG_KEY_8_15:   key_reg[1] = value;
         REG_KEY_16_23:  key_reg[2] = value;
         REG_KEY_24_31:  key_reg[3] = value;
         REG_NONCE_0_7:  nonce_lo = value;
         REG_NONCE_8_11: nonce_hi = value[31:0];
         REG_START_CTR:  start_ctr_reg = value[31:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input cfg_mode_type mode);
      logic [63:0] v;
      for (int i = REG_KEY_0_7; i <= REG_START_CTR; i++) begin
         if (mode == CFG_ONES) begin
            csr_write(REG_IDX_W'(i), '1);
         end else if (mode == CFG_ZEROS) begin
            csr_write(REG_IDX_W'(i), '0);
         end else if ($urandom_range(1)) begin
            v = {$urandom, $urandom};
            // start counter close to the wrap now and then
            if (i == REG_START_CTR && $urandom_range(2) == 0)
               v[31:0] = 32'hFFFF_FFFF - $urandom_range(1);
            csr_write(REG_IDX_W'(i), v);
         end
      end
      if (mode == CFG_RANDOM && $urandom_range(3) == 0)
         csr_write(REG_UNUSED, {$urandom, $urandom});
   endtask

   // fill the send queue with messages of mixed length; the tail may stay open
   task automatic queue_messages(input int count, input int first_len);
      int remaining;
      int drawn;
      int len;
      int r;
      plain_in_type item;
      remaining = count;
      while (remaining > 0) begin
         r = $urandom_range(99);
         if (first_len > 0) begin
            drawn = first_len;
            first_len = 0;
         end else if (r < 40) begin
            drawn = $urandom_range(1, 8);
         end else if (r < 70) begin
            drawn = $urandom_range(9, 64);
         end else begin
            drawn = $urandom_range(65, 200);
         end
         len = (drawn < remaining) ? drawn : remaining;
         for (int i = 0; i < len; i++) begin
            item.data_byte = 8'($urandom_range(255));
            item.last_byte = (i == len - 1) && (len == drawn || $urandom_range(1) == 1);
            plain_q.push_back(item);
         end
         remaining -= len;
      end
   endtask

   // hold off until everything sent has come back and the core is quiet
   task automatic wait_idle();
      do @(negedge clock); while (plain_q.size() != 0 || req_valid || cipher_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // driver: present queued bytes, predict on every accepted transaction
   always @(posedge clock) begin : driver
      plain_in_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            xor_keystream(req_data_byte, req_last_byte);
         if (!req_valid || !req_stall) begin
            if (plain_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               item = plain_q.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= item.data_byte;
               req_last_byte <= item.last_byte;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: random stall, compare each result transaction in order
   always @(posedge clock) begin : monitor
      cipher_out_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (cipher_q.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result, expected none, actual byte %02h last %0b",
                        $time, rsp_result_byte, rsp_result_last);
            end else begin
               want = cipher_q.pop_front();
               if (rsp_result_byte !== want.result_byte) begin
                  error_count++;
                  $display("%0t: result_byte mismatch, expected %02h actual %02h",
                           $time, want.result_byte, rsp_result_byte);
               end
               if (rsp_result_last !== want.result_last) begin
                  error_count++;
                  $display("%0t: result_last mismatch, expected %0b actual %0b",
                           $time, want.result_last, rsp_result_last);
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      plain_in_type item;
      logic [7:0] pattern [8];
      pattern = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA};
      for (int k = 0; k < 4; k++)
         key_reg[k] = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // single-byte messages on the reset configuration
      @(negedge clock);
      plain_q.push_back('{data_byte: 8'h00, last_byte: 1'b1});
      plain_q.push_back('{data_byte: 8'hFF, last_byte: 1'b1});
      wait_idle();

      // known key and nonce, counter 1, plus a write to an unmapped slot
      csr_write(REG_KEY_0_7,    64'h0706_0504_0302_0100);
      csr_write(REG_KEY_8_15,   64'h0f0e_0d0c_0b0a_0908);
      csr_write(REG_KEY_16_23,  64'h1716_1514_1312_1110);
      csr_write(REG_KEY_24_31,  64'h1f1e_1d1c_1b1a_1918);
      csr_write(REG_NONCE_0_7,  64'h4a00_0000_0000_0000);
      csr_write(REG_NONCE_8_11, 64'hFFFF_FFFF_0000_0000);
      csr_write(REG_START_CTR,  64'hA5A5_A5A5_0000_0001);
      csr_write(REG_UNUSED,     '1);
      @(negedge clock);
      for (int i = 0; i < 20; i++) begin
         item.data_byte = pattern[i % 8];
         item.last_byte = (i == 19);
         plain_q.push_back(item);
      end
      wait_idle();

      // random phases: extremes first (counter wrap on all ones), then random setups
      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (p < 4) begin
            send_idle_pct = 34;
            recv_idle_pct = 70;
         end else if (p < 7) begin
            send_idle_pct = 70;
            recv_idle_pct = 34;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (p == 0)
            set_config(CFG_ONES);
         else if (p == 1)
            set_config(CFG_ZEROS);
         else
            set_config(CFG_RANDOM);
         @(negedge clock);
         queue_messages(PHASE_BYTES, (p == 0) ? 130 : 0);
         wait_idle();
      end

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
